>>> src/complex_arithmetic_unit_assert.svh
// Assertion macros for the top-level file, which checks its own logic.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("complex arithmetic unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("complex arithmetic unit check failed");

`endif

>>> src/cau_pkg.sv
`timescale 1ns / 1ps
package cau_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 2 * DataW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned DenW     = ProdW;
  localparam int unsigned WideW    = DenW + FracBits;
  localparam int unsigned StepW    = $clog2(DataW);
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [2:0] ActAdd = 3'd0;
  localparam logic [2:0] ActSub = 3'd1;
  localparam logic [2:0] ActMul = 3'd2;
  localparam logic [2:0] ActDiv = 3'd3;
  localparam logic [2:0] ActCmp = 3'd4;

  localparam logic [1:0] OrdLess    = 2'd0;
  localparam logic [1:0] OrdEqual   = 2'd1;
  localparam logic [1:0] OrdGreater = 2'd2;

  localparam logic [1:0] StsOk      = 2'd0;
  localparam logic [1:0] StsOvf     = 2'd1;
  localparam logic [1:0] StsDivZero = 2'd2;

  localparam logic signed [SumW-1:0] SatMax = SumW'({1'b0, {(DataW-1){1'b1}}});
  localparam logic signed [SumW-1:0] SatMin = -SumW'({1'b1, {(DataW-1){1'b0}}});

  typedef enum logic [2:0] {
    KindLin,
    KindMul,
    KindDiv,
    KindCmp,
    KindNop
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [SumW-1:0]   x;
    logic signed [SumW-1:0]   y;
    logic        [DenW-1:0]   den;
  } item_t;

  typedef struct packed {
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
    logic        [1:0]       order;
    logic        [1:0]       status;
  } result_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [DataW-1:0] val;
  } sat_t;

  // Clamps a wide signed value to the 32-bit range.
  function automatic sat_t sat32(input logic signed [SumW-1:0] v);
    sat_t r;
    if (v > SatMax) begin
      r.ovf = 1'b1;
      r.val = DataW'(SatMax);
    end else if (v < SatMin) begin
      r.ovf = 1'b1;
      r.val = DataW'(SatMin);
    end else begin
      r.ovf = 1'b0;
      r.val = DataW'(v);
    end
    return r;
  endfunction

endpackage

>>> src/cau_front.sv
`timescale 1ns / 1ps
module cau_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [2:0]                  action_i,
  input  logic signed [31:0]          a_re_i,
  input  logic signed [31:0]          a_im_i,
  input  logic signed [31:0]          b_re_i,
  input  logic signed [31:0]          b_im_i,
  output logic                        push_o,
  output cau_pkg::item_t              item_o,
  output logic [1:0]                  inflight_o
);
  import cau_pkg::*;

  kind_e kind_s0;
  logic  is_cmp;
  logic signed [DataW-1:0] m0b, m1b;
  logic signed [DataW:0]   lin_re_d, lin_im_d;

  logic                    v1_q, v2_q;
  kind_e                   kind1_q;
  logic signed [ProdW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DataW:0]   lin_re_q, lin_im_q;
  item_t                   item_d, item_q;

  always_comb begin
    case (action_i)
      ActAdd, ActSub: kind_s0 = KindLin;
      ActMul:         kind_s0 = KindMul;
      ActDiv:         kind_s0 = KindDiv;
      ActCmp:         kind_s0 = KindCmp;
      default:        kind_s0 = KindNop;
    endcase
  end

  // Compare reuses the first two multipliers for the squares of the left operand.
  assign is_cmp = (kind_s0 == KindCmp);
  assign m0b    = is_cmp ? a_re_i : b_re_i;
  assign m1b    = is_cmp ? a_im_i : b_im_i;

  always_comb begin
    if (action_i == ActSub) begin
      lin_re_d = {a_re_i[DataW-1], a_re_i} - {b_re_i[DataW-1], b_re_i};
      lin_im_d = {a_im_i[DataW-1], a_im_i} - {b_im_i[DataW-1], b_im_i};
    end else begin
      lin_re_d = {a_re_i[DataW-1], a_re_i} + {b_re_i[DataW-1], b_re_i};
      lin_im_d = {a_im_i[DataW-1], a_im_i} + {b_im_i[DataW-1], b_im_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= fire_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind1_q  <= kind_s0;
    p0_q     <= a_re_i * m0b;
    p1_q     <= a_im_i * m1b;
    p2_q     <= a_re_i * b_im_i;
    p3_q     <= a_im_i * b_re_i;
    p4_q     <= b_re_i * b_re_i;
    p5_q     <= b_im_i * b_im_i;
    lin_re_q <= lin_re_d;
    lin_im_q <= lin_im_d;
    item_q   <= item_d;
  end

  always_comb begin
    item_d.kind = kind1_q;
    item_d.x    = '0;
    item_d.y    = '0;
    item_d.den  = DenW'(p4_q) + DenW'(p5_q);
    case (kind1_q)
      KindLin: begin
        item_d.x = SumW'(lin_re_q);
        item_d.y = SumW'(lin_im_q);
      end
      KindMul: begin
        item_d.x = SumW'(p0_q) - SumW'(p1_q);
        item_d.y = SumW'(p2_q) + SumW'(p3_q);
      end
      KindDiv: begin
        item_d.x = SumW'(p0_q) + SumW'(p1_q);
        item_d.y = SumW'(p3_q) - SumW'(p2_q);
      end
      KindCmp: begin
        item_d.x = SumW'(p0_q) + SumW'(p1_q);
      end
      default: begin
        item_d.x = '0;
      end
    endcase
  end

  assign push_o     = v2_q;
  assign item_o     = item_q;
  assign inflight_o = {1'b0, v1_q} + {1'b0, v2_q};

endmodule

>>> src/cau_fifo.sv
`timescale 1ns / 1ps
module cau_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  cau_pkg::item_t             item_i,
  input  logic                       pop_i,
  output cau_pkg::item_t             item_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [cau_pkg::QPtrW:0]    count_o
);
  import cau_pkg::*;

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign count_o = cnt_q;

endmodule

>>> src/cau_back.sv
`timescale 1ns / 1ps
module cau_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  cau_pkg::item_t    item_i,
  output logic              pop_o,
  output logic              valid_o,
  output cau_pkg::result_t  result_o
);
  import cau_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             valid_q, valid_d;
  result_t          res_q, res_d;
  logic [DenW-1:0]  den_q, den_d;

  logic [DenW-1:0]  rem_q [2];
  logic [DenW-1:0]  rem_d [2];
  logic [DataW-1:0] low_q [2];
  logic [DataW-1:0] low_d [2];
  logic [DataW-1:0] quo_q [2];
  logic [DataW-1:0] quo_d [2];
  logic             neg_q [2];
  logic             neg_d [2];
  logic             ovf_q [2];
  logic             ovf_d [2];

  logic signed [SumW-1:0] lane_in  [2];
  logic        [DenW-1:0] lane_mag [2];
  logic        [WideW-1:0] lane_wide [2];
  logic        [DenW:0]   lane_r2  [2];
  logic                   lane_ge  [2];
  logic        [DataW:0]  lane_q33 [2];
  logic signed [SumW-1:0] lane_val [2];
  sat_t                   lane_sat [2];
  sat_t                   sat_x, sat_y;

  always_comb begin
    lane_in[0] = item_i.x;
    lane_in[1] = item_i.y;
    for (int l = 0; l < 2; l++) begin
      lane_mag[l]  = lane_in[l][SumW-1] ? DenW'(-lane_in[l]) : DenW'(lane_in[l]);
      lane_wide[l] = WideW'(lane_mag[l]) << FracBits;
      lane_r2[l]   = {rem_q[l], low_q[l][DataW-1]};
      lane_ge[l]   = (lane_r2[l] >= {1'b0, den_q});
      lane_q33[l]  = {1'b0, quo_q[l]} + (DataW+1)'(neg_q[l] && (rem_q[l] != '0));
      lane_val[l]  = neg_q[l] ? -SumW'(lane_q33[l]) : SumW'(lane_q33[l]);
      lane_sat[l]  = sat32(lane_val[l]);
      if (ovf_q[l]) begin
        lane_sat[l].ovf = 1'b1;
        lane_sat[l].val = neg_q[l] ? DataW'(SatMin) : DataW'(SatMax);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    res_d   = res_q;
    den_d   = den_q;
    pop_o   = 1'b0;
    sat_x   = sat32(item_i.x);
    sat_y   = sat32(item_i.y);
    for (int l = 0; l < 2; l++) begin
      rem_d[l] = rem_q[l];
      low_d[l] = low_q[l];
      quo_d[l] = quo_q[l];
      neg_d[l] = neg_q[l];
      ovf_d[l] = ovf_q[l];
    end
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o        = 1'b1;
          res_d        = '0;
          res_d.order  = OrdLess;
          res_d.status = StsOk;
          case (item_i.kind)
            KindLin: begin
              valid_d      = 1'b1;
              res_d.re     = sat_x.val;
              res_d.im     = sat_y.val;
              res_d.status = (sat_x.ovf || sat_y.ovf) ? StsOvf : StsOk;
            end
            KindMul: begin
              valid_d      = 1'b1;
              sat_x        = sat32(item_i.x >>> FracBits);
              sat_y        = sat32(item_i.y >>> FracBits);
              res_d.re     = sat_x.val;
              res_d.im     = sat_y.val;
              res_d.status = (sat_x.ovf || sat_y.ovf) ? StsOvf : StsOk;
            end
            KindCmp: begin
              valid_d = 1'b1;
              if (DenW'(item_i.x) < item_i.den) begin
                res_d.order = OrdLess;
              end else if (DenW'(item_i.x) == item_i.den) begin
                res_d.order = OrdEqual;
              end else begin
                res_d.order = OrdGreater;
              end
            end
            KindDiv: begin
              if (item_i.den == '0) begin
                valid_d      = 1'b1;
                res_d.status = StsDivZero;
              end else begin
                den_d   = item_i.den;
                cnt_d   = '1;
                state_d = StDiv;
                for (int l = 0; l < 2; l++) begin
                  neg_d[l] = lane_in[l][SumW-1];
                  ovf_d[l] = (WideW'(lane_mag[l]) >= (WideW'(item_i.den) << FracBits));
                  rem_d[l] = DenW'(lane_wide[l] >> DataW);
                  low_d[l] = lane_wide[l][DataW-1:0];
                  quo_d[l] = '0;
                end
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      StDiv: begin
        for (int l = 0; l < 2; l++) begin
          rem_d[l] = lane_ge[l] ? DenW'(lane_r2[l] - {1'b0, den_q}) : lane_r2[l][DenW-1:0];
          low_d[l] = {low_q[l][DataW-2:0], 1'b0};
          quo_d[l] = {quo_q[l][DataW-2:0], lane_ge[l]};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StFin;
        end
      end
      StFin: begin
        valid_d      = 1'b1;
        res_d        = '0;
        res_d.re     = lane_sat[0].val;
        res_d.im     = lane_sat[1].val;
        res_d.order  = OrdLess;
        res_d.status = (lane_sat[0].ovf || lane_sat[1].ovf) ? StsOvf : StsOk;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    den_q <= den_d;
    for (int l = 0; l < 2; l++) begin
      rem_q[l] <= rem_d[l];
      low_q[l] <= low_d[l];
      quo_q[l] <= quo_d[l];
      neg_q[l] <= neg_d[l];
      ovf_q[l] <= ovf_d[l];
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

>>> src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Complex arithmetic unit on signed Q16.16 operands. A transaction is taken
// at a rising edge where start_i is high and busy_o is low; it carries an
// action (add, subtract, multiply, divide, magnitude compare) and two complex
// operands. Exactly one result comes back for every transaction, in order,
// on res_re_o, res_im_o, order_o and status_o, shown for a single cycle with
// valid_o high. The receiver cannot stall, so the result must be captured in
// that cycle. A front section forms all products and sums in two pipeline
// stages and writes a four-entry queue; a back section drains the queue.
// Add, subtract, multiply, compare and unused codes are done by the back
// section from its idle state, so these run at one transaction per clock
// while busy_o stays low. Divide is done by a restoring divider with two
// lanes (real and imaginary) that retire one quotient bit per cycle, so a
// nonzero-divisor divide holds the back section through a load, 32 quotient
// steps and a final rounding and saturation step. busy_o rises when the
// queue plus the front stages hold four transactions, which happens only
// behind divides. Results that do not fit saturate with status 1; a zero
// divisor returns zeros with status 2. No clearing pass is needed after reset.
module complex_arithmetic_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               valid_o,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic [1:0]         order_o,
  output logic [1:0]         status_o
);
  import cau_pkg::*;

  `include "complex_arithmetic_unit_assert.svh"

  logic           fire;
  logic           push;
  item_t          push_item;
  logic [1:0]     inflight;
  logic           pop;
  item_t          head_item;
  logic           q_empty;
  logic           q_full;
  logic [QPtrW:0] q_count;
  result_t        result;

  // Reserve a queue slot for every transaction still in the front stages, so
  // the front never has to stall.
  assign busy_o = ((QPtrW+2)'(q_count) + (QPtrW+2)'(inflight)) >= (QPtrW+2)'(QDepth);
  assign fire   = start_i && !busy_o;

  cau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .action_i   (action_i),
    .a_re_i     (a_re_i),
    .a_im_i     (a_im_i),
    .b_re_i     (b_re_i),
    .b_im_i     (b_im_i),
    .push_o     (push),
    .item_o     (push_item),
    .inflight_o (inflight)
  );

  cau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  cau_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (q_empty),
    .item_i   (head_item),
    .pop_o    (pop),
    .valid_o  (valid_o),
    .result_o (result)
  );

  assign res_re_o = result.re;
  assign res_im_o = result.im;
  assign order_o  = result.order;
  assign status_o = result.status;

  // The slot reservation must keep the queue from ever being written when full.
  `CAU_ASSERT_SAME(a_no_overflow, clk_i, rst_ni, push, !q_full || pop)
  // A zero-divisor result carries zero parts.
  `CAU_ASSERT_SAME(a_divzero_zero, clk_i, rst_ni, valid_o && (status_o == StsDivZero),
                   (res_re_o == '0) && (res_im_o == '0))
  // An ordering code other than less only comes with a clean zero result.
  `CAU_ASSERT_SAME(a_cmp_clean, clk_i, rst_ni, valid_o && (order_o != OrdLess),
                   (status_o == StsOk) && (res_re_o == '0) && (res_im_o == '0))
  // An accepted transaction is counted in flight once the first front stage has registered it.
  `CAU_ASSERT_NEXT(a_front_flow, clk_i, rst_ni, fire, inflight != 2'd0)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the complex arithmetic unit.
//
// An initial block builds a queue of pending transactions: a directed part
// first, then random ones. A driver at the falling clock edge presents them
// on start_i in bursts with random gaps between the bursts. A marker in that
// queue makes the driver pause until every expected result has come back.
// At the rising edge a monitor does two things. It predicts each accepted
// transaction and appends the prediction to a queue. It also compares each
// result strobe against the oldest prediction, field by field. The block
// cannot stall its results, so nothing is held off on the output side.
module tb;
  import cau_pkg::*;

  typedef struct {
    logic              drain;  // marker: wait for all results before going on
    logic [2:0]        action;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } op_t;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [1:0]         order;
    logic [1:0]         status;
  } answer_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [2:0]         action_i;
  logic signed [31:0] a_re_i;
  logic signed [31:0] a_im_i;
  logic signed [31:0] b_re_i;
  logic signed [31:0] b_im_i;
  logic               valid_o;
  logic signed [31:0] res_re_o;
  logic signed [31:0] res_im_o;
  logic [1:0]         order_o;
  logic [1:0]         status_o;

  op_t     pending_ops[$];
  answer_t expected_answers[$];
  int      mismatches;
  logic    taken;       // the transaction on the inputs was accepted last edge
  int      burst_left;
  int      gap_left;

  complex_arithmetic_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .action_i(action_i),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .valid_o (valid_o),
    .res_re_o(res_re_o),
    .res_im_o(res_im_o),
    .order_o (order_o),
    .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // Clamps a wide signed value to 32 bits and raises the overflow flag when it does not fit.
  function automatic logic signed [31:0] clamp32(input logic signed [129:0] v,
                                                 inout logic [1:0] st);
    if (v > 130'sh7FFFFFFF) begin
      st = StsOvf;
      return 32'sh7FFFFFFF;
    end
    if (v < -130'sh80000000) begin
      st = StsOvf;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Floor of num * 2^16 / den for den > 0.
  function automatic logic signed [129:0] floor_quotient(input logic signed [129:0] num,
                                                         input logic [127:0] den);
    logic         neg;
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] r;
    neg = num < 0;
    mag = neg ? 128'(-num) : 128'(num);
    q = (mag << FracBits) / den;
    r = (mag << FracBits) % den;
    if (neg && r != 0) q = q + 1;
    return neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
  endfunction

  function automatic answer_t complex_result(input op_t op);
    answer_t             ans;
    logic signed [129:0] ar, ai, br, bi, x, y;
    logic [127:0]        mag_a, mag_b;
    ar = op.a_re;
    ai = op.a_im;
    br = op.b_re;
    bi = op.b_im;
    ans.re = '0;
    ans.im = '0;
    ans.order = OrdLess;
    ans.status = StsOk;
    mag_a = 128'(ar * ar + ai * ai);
    mag_b = 128'(br * br + bi * bi);
    case (op.action)
      ActAdd: begin
        ans.re = clamp32(ar + br, ans.status);
        ans.im = clamp32(ai + bi, ans.status);
      end
      ActSub: begin
        ans.re = clamp32(ar - br, ans.status);
        ans.im = clamp32(ai - bi, ans.status);
      end
      ActMul: begin
        x = ar * br - ai * bi;
        y = ar * bi + ai * br;
        ans.re = clamp32(x >>> FracBits, ans.status);
        ans.im = clamp32(y >>> FracBits, ans.status);
      end
      ActDiv: begin
        if (mag_b == 0) begin
          ans.status = StsDivZero;
        end else begin
          x = ar * br + ai * bi;
          y = ai * br - ar * bi;
          ans.re = clamp32(floor_quotient(x, mag_b), ans.status);
          ans.im = clamp32(floor_quotient(y, mag_b), ans.status);
        end
      end
      ActCmp: begin
        ans.order = (mag_a < mag_b) ? OrdLess : (mag_a == mag_b) ? OrdEqual : OrdGreater;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Monitor: record accepted transactions and check result strobes.
  always @(posedge clk_i) begin
    answer_t want;
    op_t     op;
    if (rst_ni) begin
      taken <= start_i && !busy_o;
      if (start_i && !busy_o) begin
        op.drain = 1'b0;
        op.action = action_i;
        op.a_re = a_re_i;
        op.a_im = a_im_i;
        op.b_re = b_re_i;
        op.b_im = b_im_i;
        expected_answers.push_back(complex_result(op));
      end
      if (valid_o) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected result", res_re_o, 32'h0);
        end else begin
          want = expected_answers.pop_front();
          if (res_re_o !== want.re) report_mismatch("res_re", res_re_o, want.re);
          if (res_im_o !== want.im) report_mismatch("res_im", res_im_o, want.im);
          if (order_o !== want.order) begin
            report_mismatch("order", 32'(order_o), 32'(want.order));
          end
          if (status_o !== want.status) begin
            report_mismatch("status", 32'(status_o), 32'(want.status));
          end
        end
      end
    end else begin
      taken <= 1'b0;
    end
  end

  // Driver: holds a transaction until accepted, then moves to the next one.
  always @(negedge clk_i) begin
    op_t op;
    if (rst_ni && (!start_i || taken)) begin
      // A pause marker is consumed only once everything has come back.
      if (pending_ops.size() != 0 && pending_ops[0].drain) begin
        if (expected_answers.size() == 0 && !(start_i && !taken)) begin
          void'(pending_ops.pop_front());
        end
        start_i <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        op = pending_ops.pop_front();
        start_i <= 1'b1;
        action_i <= op.action;
        a_re_i <= op.a_re;
        a_im_i <= op.a_im;
        b_re_i <= op.b_re;
        b_im_i <= op.b_im;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  task automatic add_op(input logic [2:0] act, input logic [31:0] are,
                        input logic [31:0] aim, input logic [31:0] bre,
                        input logic [31:0] bim);
    op_t op;
    op.drain = 1'b0;
    op.action = act;
    op.a_re = are;
    op.a_im = aim;
    op.b_re = bre;
    op.b_im = bim;
    pending_ops.push_back(op);
  endtask

  task automatic add_drain();
    op_t op;
    op = '{default: '0};
    op.drain = 1'b1;
    pending_ops.push_back(op);
  endtask

  // Operand value: mostly small Q16.16 numbers, sometimes extremes or any word.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3: return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
      4: return $urandom_range(0, 3) - 2;
      default: return $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
    endcase
  endfunction

  initial begin
    logic [2:0] act;
    logic [31:0] bre, bim;
    rst_ni = 1'b0;
    start_i = 1'b0;
    action_i = ActAdd;
    a_re_i = '0;
    a_im_i = '0;
    b_re_i = '0;
    b_im_i = '0;
    mismatches = 0;
    burst_left = 0;
    gap_left = 0;

    // Directed part: extremes, every action, overflow, divide by zero,
    // negative floor rounding, equal magnitudes and the unused codes.
    add_op(ActAdd, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF);
    add_op(ActAdd, 32'h00010000, 32'hFFFF0000, 32'h00020000, 32'h00008000);
    add_op(ActSub, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF);
    add_op(ActSub, 32'h00030000, 32'h00000000, 32'h00010000, 32'h00010000);
    add_op(ActMul, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    add_op(ActMul, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    add_op(ActMul, 32'hFFFFFFFF, 32'h00000000, 32'h00000001, 32'h00000000);
    add_op(ActMul, 32'h00020000, 32'h00010000, 32'h00030000, 32'hFFFF0000);
    add_op(ActDiv, 32'h00010000, 32'h00010000, 32'h00000000, 32'h00000000);
    add_op(ActDiv, 32'h00010000, 32'h00000000, 32'h00030000, 32'h00000000);
    add_op(ActDiv, 32'hFFFF0000, 32'h00000000, 32'h00030000, 32'h00000000);
    add_op(ActDiv, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'h00000000);
    add_op(ActDiv, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    add_op(ActDiv, 32'h00000001, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_op(ActCmp, 32'h00030000, 32'h00040000, 32'h00050000, 32'h00000000);
    add_op(ActCmp, 32'h00010000, 32'h00000000, 32'h00020000, 32'h00000000);
    add_op(ActCmp, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_op(ActCmp, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000);
    add_op(3'd5, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0);
    add_op(3'd6, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_op(3'd7, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'h00000000);
    add_drain();

    // Random part. Divides are kept a minority because each one occupies
    // the back section for many cycles.
    for (int i = 0; i < 1900; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: act = ActAdd;
        4, 5, 6, 7: act = ActSub;
        8, 9, 10, 11: act = ActMul;
        12, 13, 14: act = ActDiv;
        15, 16, 17: act = ActCmp;
        default: act = 3'($urandom_range(5, 7));
      endcase
      bre = pick_value();
      bim = pick_value();
      if (act == ActDiv && $urandom_range(0, 19) == 0) begin
        bre = '0;
        bim = '0;
      end
      if (act == ActCmp && $urandom_range(0, 4) == 0) begin
        add_op(act, bim, bre, bre, bim);
      end else begin
        add_op(act, pick_value(), pick_value(), bre, bim);
      end
      if (i == 700 || i == 1400) add_drain();
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Checked at the falling edge, after the monitor has settled.
    while (pending_ops.size() != 0 || (start_i && !taken) || expected_answers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (60) @(posedge clk_i);
    if (expected_answers.size() != 0) begin
      $display("%0d results never arrived", expected_answers.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
